// ===== rtl/gdc_pkg.sv =====
// Shared types and constants for the go-to-goal drive controller.
// Holds the transaction payload structs, register indexes and the CORDIC angle table.
// No dependencies.
package gdc_pkg;

  typedef struct packed {
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic [15:0]        robot_heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] fwd_speed;
    logic signed [31:0] turn_speed;
    logic               target_reached;
  } out_t;

  typedef struct packed {
    logic en;
  } pipe_ctl_t;

  localparam logic [2:0] CFG_TARGET_X        = 3'd0;
  localparam logic [2:0] CFG_TARGET_Y        = 3'd1;
  localparam logic [2:0] CFG_VELOCITY_GAIN   = 3'd2;
  localparam logic [2:0] CFG_TURNING_GAIN    = 3'd3;
  localparam logic [2:0] CFG_REACH_THRESHOLD = 3'd4;

  localparam logic signed [31:0] RST_TARGET_X        = 32'sd0;
  localparam logic signed [31:0] RST_TARGET_Y        = 32'sd0;
  localparam logic signed [15:0] RST_VELOCITY_GAIN   = -16'sd256;
  localparam logic signed [15:0] RST_TURNING_GAIN    = -16'sd6400;
  localparam logic [30:0]        RST_REACH_THRESHOLD = 31'd655;

  // Reciprocal of the CORDIC gain, 0.60725293501 in Q32.
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Arctangent of 2^-idx as a binary angle of ab bits, rounded half up.
  function automatic logic [31:0] atan_step(input int idx, input int ab);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[idx[4:0]]};
    if (ab < 32) begin
      t = (t + (33'd1 << (31 - ab))) >> (32 - ab);
    end
    return t[31:0];
  endfunction

endpackage

// ===== rtl/go_to_goal_drive_controller.sv =====
// Go-to-goal drive controller: a fully pipelined datapath that accepts one transaction per
// cycle while the result side does not stall and returns one result per input, in order.
// The latency is set by the two chains of CORDIC stages (vectoring for distance and
// bearing, rotation for cosine and sine), the offset register in front of the vectoring
// chain, three stages for the distance multiply and angle fold, three stages for the drive
// multiply, rounding and saturation, and the output register. A two-entry output buffer
// lets the input side keep accepting while its second entry fills after the result side
// stalls. The user must write registers through the configuration port only while no
// transaction is in flight; the block itself does not enforce this.
// Depends on gdc_pkg, gdc_vectoring, gdc_distance, gdc_rotation and gdc_drive.
module go_to_goal_drive_controller #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gdc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gdc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int XW     = 57;
  localparam int DW     = XW - 20;
  localparam int CW     = 34;

  logic signed [31:0] target_x_r, target_y_r;
  logic signed [15:0] velocity_gain_r, turning_gain_r;
  logic [30:0]        reach_threshold_r;

  gdc_pkg::pipe_ctl_t ctl;

  logic                  vec_valid;
  logic signed [XW-1:0]  vec_x;
  logic [ANGLE_BITS-1:0] vec_z;
  logic [15:0]           vec_hd;

  logic                       dst_valid, dst_reached, dst_flip;
  logic [DW-1:0]              dst_dist;
  logic signed [ANGLE_BITS:0] dst_angle;

  logic                 rot_valid, rot_reached, rot_flip;
  logic [DW-1:0]        rot_dist;
  logic signed [CW-1:0] rot_cos, rot_sin;

  logic          drv_valid;
  gdc_pkg::out_t drv_data;

  logic          out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  gdc_pkg::out_t out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;
  logic          arrive, take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r        <= gdc_pkg::RST_TARGET_X;
      target_y_r        <= gdc_pkg::RST_TARGET_Y;
      velocity_gain_r   <= gdc_pkg::RST_VELOCITY_GAIN;
      turning_gain_r    <= gdc_pkg::RST_TURNING_GAIN;
      reach_threshold_r <= gdc_pkg::RST_REACH_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gdc_pkg::CFG_TARGET_X:        target_x_r        <= cfg_data;
        gdc_pkg::CFG_TARGET_Y:        target_y_r        <= cfg_data;
        gdc_pkg::CFG_VELOCITY_GAIN:   velocity_gain_r   <= cfg_data[15:0];
        gdc_pkg::CFG_TURNING_GAIN:    turning_gain_r    <= cfg_data[15:0];
        gdc_pkg::CFG_REACH_THRESHOLD: reach_threshold_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign ctl.en   = !skid_valid_r;
  assign in_stall = skid_valid_r;

  gdc_vectoring #(.STAGES(STAGES), .ANGLE_BITS(ANGLE_BITS), .XW(XW)) u_vec (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_valid(in_valid), .in_data(in_data),
    .target_x(target_x_r), .target_y(target_y_r),
    .out_valid(vec_valid), .out_x(vec_x), .out_z(vec_z), .out_heading(vec_hd)
  );

  gdc_distance #(.ANGLE_BITS(ANGLE_BITS), .XW(XW), .DW(DW)) u_dst (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_valid(vec_valid), .in_x(vec_x), .in_z(vec_z), .in_heading(vec_hd),
    .reach_threshold(reach_threshold_r),
    .out_valid(dst_valid), .out_dist(dst_dist), .out_reached(dst_reached),
    .out_angle(dst_angle), .out_flip(dst_flip)
  );

  gdc_rotation #(.STAGES(STAGES), .ANGLE_BITS(ANGLE_BITS), .DW(DW), .CW(CW)) u_rot (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_valid(dst_valid), .in_dist(dst_dist), .in_reached(dst_reached),
    .in_angle(dst_angle), .in_flip(dst_flip),
    .out_valid(rot_valid), .out_dist(rot_dist), .out_reached(rot_reached),
    .out_flip(rot_flip), .out_cos(rot_cos), .out_sin(rot_sin)
  );

  gdc_drive #(.DW(DW), .CW(CW)) u_drv (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .in_valid(rot_valid), .in_dist(rot_dist), .in_reached(rot_reached),
    .in_flip(rot_flip), .in_cos(rot_cos), .in_sin(rot_sin),
    .velocity_gain(velocity_gain_r), .turning_gain(turning_gain_r),
    .out_valid(drv_valid), .out_data(drv_data)
  );

  always_comb begin
    arrive         = ctl.en && drv_valid;
    take           = out_valid_r && !out_stall;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = arrive;
        out_data_nxt  = drv_data;
      end
    end else if (arrive) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = drv_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/gdc_vectoring.sv =====
// Offset formation and vectoring CORDIC pipeline: magnitude and bearing of target minus robot.
// Depends on gdc_pkg.
module gdc_vectoring #(
  parameter int STAGES     = 16,
  parameter int ANGLE_BITS = 16,
  parameter int XW         = 57
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gdc_pkg::pipe_ctl_t    ctl,
  input  logic                  in_valid,
  input  gdc_pkg::in_t          in_data,
  input  logic signed [31:0]    target_x,
  input  logic signed [31:0]    target_y,
  output logic                  out_valid,
  output logic signed [XW-1:0]  out_x,
  output logic [ANGLE_BITS-1:0] out_z,
  output logic [15:0]           out_heading
);

  localparam logic [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  logic signed [XW-1:0]  x_r  [0:STAGES];
  logic signed [XW-1:0]  y_r  [0:STAGES];
  logic [ANGLE_BITS-1:0] z_r  [0:STAGES];
  logic [15:0]           hd_r [0:STAGES];
  logic                  v_r  [0:STAGES];

  logic signed [32:0]    dx, dy;
  logic signed [XW-1:0]  x0, y0;
  logic [ANGLE_BITS-1:0] z0;

  always_comb begin
    dx = $signed({target_x[31], target_x}) - $signed({in_data.robot_x[31], in_data.robot_x});
    dy = $signed({target_y[31], target_y}) - $signed({in_data.robot_y[31], in_data.robot_y});
    x0 = $signed({{(XW-53){dx[32]}}, dx, 20'd0});
    y0 = $signed({{(XW-53){dy[32]}}, dy, 20'd0});
    z0 = '0;
    if (dx[32]) begin
      x0 = -x0;
      y0 = -y0;
      z0 = HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ctl.en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x_r[0]  <= x0;
      y_r[0]  <= y0;
      z_r[0]  <= z0;
      hd_r[0] <= in_data.robot_heading;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [31:0] A32 = gdc_pkg::atan_step(i, ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] A = A32[ANGLE_BITS-1:0];
    logic signed [XW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        hd_r[i+1] <= hd_r[i];
        if (y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - A;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + A;
        end
      end
    end
  end

  assign out_valid   = v_r[STAGES];
  assign out_x       = x_r[STAGES];
  assign out_z       = z_r[STAGES];
  assign out_heading = hd_r[STAGES];

endmodule

// ===== rtl/gdc_distance.sv =====
// Gain-compensated distance, reach test and folding of the relative heading angle.
// Depends on gdc_pkg.
module gdc_distance #(
  parameter int ANGLE_BITS = 16,
  parameter int XW         = 57,
  parameter int DW         = 37
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gdc_pkg::pipe_ctl_t           ctl,
  input  logic                         in_valid,
  input  logic signed [XW-1:0]         in_x,
  input  logic [ANGLE_BITS-1:0]        in_z,
  input  logic [15:0]                  in_heading,
  input  logic [30:0]                  reach_threshold,
  output logic                         out_valid,
  output logic [DW-1:0]                out_dist,
  output logic                         out_reached,
  output logic signed [ANGLE_BITS:0]   out_angle,
  output logic                         out_flip
);

  localparam int HW  = XW - 23;
  localparam int PHW = HW + 32;
  localparam int PLW = 22 + 32;
  localparam logic signed [ANGLE_BITS:0] HALF    = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);
  localparam logic signed [ANGLE_BITS:0] QUARTER = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 2);

  logic [XW-2:0]          mag;
  logic [PHW-1:0]         ph_r;
  logic [PLW-1:0]         pl_r;
  logic [ANGLE_BITS-1:0]  z1_r, z2_r;
  logic [15:0]            hd1_r, hd2_r;
  logic                   v1_r, v2_r, v3_r;
  logic [PLW:0]           pl_rnd;
  logic [PHW:0]           sum;
  logic [DW-1:0]          dist_r, dist3_r;
  logic [ANGLE_BITS+15:0] hd_wide;
  logic [ANGLE_BITS-1:0]  phi;
  logic signed [ANGLE_BITS:0] s_nxt, s_r;
  logic                   flip_nxt, flip_r, reached_r;

  assign mag = in_x[XW-1] ? '0 : in_x[XW-2:0];

  always_comb begin
    pl_rnd  = {1'b0, pl_r} + ((PLW+1)'(1) << 51);
    sum     = {1'b0, ph_r} + (PHW+1)'(pl_rnd[PLW:22]);
    hd_wide = {hd2_r, {ANGLE_BITS{1'b0}}};
    phi     = hd_wide[ANGLE_BITS+15:16] - z2_r;
    s_nxt   = $signed({phi[ANGLE_BITS-1], phi});
    flip_nxt = 1'b0;
    if (s_nxt > QUARTER) begin
      s_nxt    = s_nxt - HALF;
      flip_nxt = 1'b1;
    end else if (s_nxt < -QUARTER) begin
      s_nxt    = s_nxt + HALF;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctl.en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ph_r      <= PHW'(mag[XW-2:22]) * PHW'(gdc_pkg::INV_GAIN_Q32);
      pl_r      <= PLW'(mag[21:0]) * PLW'(gdc_pkg::INV_GAIN_Q32);
      z1_r      <= in_z;
      hd1_r     <= in_heading;
      dist_r    <= sum[PHW:30];
      z2_r      <= z1_r;
      hd2_r     <= hd1_r;
      dist3_r   <= dist_r;
      reached_r <= dist_r <= DW'(reach_threshold);
      s_r       <= s_nxt;
      flip_r    <= flip_nxt;
    end
  end

  assign out_valid   = v3_r;
  assign out_dist    = dist3_r;
  assign out_reached = reached_r;
  assign out_angle   = s_r;
  assign out_flip    = flip_r;

endmodule

// ===== rtl/gdc_rotation.sv =====
// Rotation CORDIC pipeline producing cosine and sine of the folded relative angle.
// Depends on gdc_pkg.
module gdc_rotation #(
  parameter int STAGES     = 16,
  parameter int ANGLE_BITS = 16,
  parameter int DW         = 37,
  parameter int CW         = 34
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gdc_pkg::pipe_ctl_t         ctl,
  input  logic                       in_valid,
  input  logic [DW-1:0]              in_dist,
  input  logic                       in_reached,
  input  logic signed [ANGLE_BITS:0] in_angle,
  input  logic                       in_flip,
  output logic                       out_valid,
  output logic [DW-1:0]              out_dist,
  output logic                       out_reached,
  output logic                       out_flip,
  output logic signed [CW-1:0]       out_cos,
  output logic signed [CW-1:0]       out_sin
);

  localparam logic [31:0] C0_32 = gdc_pkg::INV_GAIN_Q32 >> 2;

  logic signed [CW-1:0]       c_r  [0:STAGES];
  logic signed [CW-1:0]       sn_r [0:STAGES];
  logic signed [ANGLE_BITS:0] s_r  [0:STAGES];
  logic [DW-1:0]              d_r  [0:STAGES];
  logic                       rc_r [0:STAGES];
  logic                       fl_r [0:STAGES];
  logic                       v_r  [0:STAGES];

  always_comb begin
    c_r[0]  = $signed(CW'(C0_32));
    sn_r[0] = '0;
    s_r[0]  = in_angle;
    d_r[0]  = in_dist;
    rc_r[0] = in_reached;
    fl_r[0] = in_flip;
    v_r[0]  = in_valid;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [31:0] A32 = gdc_pkg::atan_step(i, ANGLE_BITS);
    localparam logic signed [ANGLE_BITS:0] A = $signed({1'b0, A32[ANGLE_BITS-1:0]});
    logic signed [CW-1:0] cs, ss;
    assign cs = c_r[i] >>> i;
    assign ss = sn_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        d_r[i+1]  <= d_r[i];
        rc_r[i+1] <= rc_r[i];
        fl_r[i+1] <= fl_r[i];
        if (!s_r[i][ANGLE_BITS]) begin
          c_r[i+1]  <= c_r[i] - ss;
          sn_r[i+1] <= sn_r[i] + cs;
          s_r[i+1]  <= s_r[i] - A;
        end else begin
          c_r[i+1]  <= c_r[i] + ss;
          sn_r[i+1] <= sn_r[i] - cs;
          s_r[i+1]  <= s_r[i] + A;
        end
      end
    end
  end

  assign out_valid   = v_r[STAGES];
  assign out_dist    = d_r[STAGES];
  assign out_reached = rc_r[STAGES];
  assign out_flip    = fl_r[STAGES];
  assign out_cos     = c_r[STAGES];
  assign out_sin     = sn_r[STAGES];

endmodule

// ===== rtl/gdc_drive.sv =====
// Drive output stages: gain times distance times trig value, rounding and saturation.
// Depends on gdc_pkg.
module gdc_drive #(
  parameter int DW = 37,
  parameter int CW = 34
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gdc_pkg::pipe_ctl_t   ctl,
  input  logic                 in_valid,
  input  logic [DW-1:0]        in_dist,
  input  logic                 in_reached,
  input  logic                 in_flip,
  input  logic signed [CW-1:0] in_cos,
  input  logic signed [CW-1:0] in_sin,
  input  logic signed [15:0]   velocity_gain,
  input  logic signed [15:0]   turning_gain,
  output logic                 out_valid,
  output gdc_pkg::out_t        out_data
);

  localparam int TW  = CW + 2;
  localparam int PW  = DW + 17;
  localparam int AW  = PW - 1;
  localparam int BW  = TW - 1;
  localparam int HW  = AW - 24;
  localparam int QHW = HW + BW;
  localparam int QLW = 24 + BW;

  logic signed [TW-1:0] cf, sf, tv, tt;
  logic signed [PW-1:0] pv_r, pt_r;
  logic signed [TW-1:0] tv_r, tt_r;
  logic                 v1_r, v2_r, v3_r, rc1_r, rc2_r;
  logic [AW-1:0]        av, at;
  logic [BW-1:0]        bv, bt;
  logic [QHW-1:0]       qhv_r, qht_r;
  logic [QLW-1:0]       qlv_r, qlt_r;
  logic                 nv_r, nt_r;
  gdc_pkg::out_t        res_nxt, res_r;

  function automatic logic signed [31:0] finish(input logic [QHW-1:0] qh,
                                                input logic [QLW-1:0] ql,
                                                input logic neg);
    logic [QLW:0]   part;
    logic [QHW:0]   sum;
    logic [QHW-14:0] r;
    part = {1'b0, ql} + ((QLW+1)'(1) << 37);
    sum  = {1'b0, qh} + (QHW+1)'(part[QLW:24]);
    r    = sum[QHW:14];
    if (neg) begin
      if (r > (QHW-13)'(33'h080000000)) begin
        return 32'sh80000000;
      end
      return -$signed(r[31:0]);
    end
    if (r > (QHW-13)'(32'h7FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end
    return $signed(r[31:0]);
  endfunction

  always_comb begin
    cf = TW'(in_cos);
    sf = TW'(in_sin);
    if (in_flip) begin
      cf = -cf;
      sf = -sf;
    end
    tv = -cf;
    tt = sf;
    av = pv_r[PW-1] ? AW'(-pv_r) : AW'(pv_r);
    at = pt_r[PW-1] ? AW'(-pt_r) : AW'(pt_r);
    bv = tv_r[TW-1] ? BW'(-tv_r) : BW'(tv_r);
    bt = tt_r[TW-1] ? BW'(-tt_r) : BW'(tt_r);
    res_nxt.target_reached = rc2_r;
    res_nxt.fwd_speed      = rc2_r ? 32'sd0 : finish(qhv_r, qlv_r, nv_r);
    res_nxt.turn_speed     = rc2_r ? 32'sd0 : finish(qht_r, qlt_r, nt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctl.en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      pv_r  <= PW'(velocity_gain) * $signed(PW'({1'b0, in_dist}));
      pt_r  <= PW'(turning_gain) * $signed(PW'({1'b0, in_dist}));
      tv_r  <= tv;
      tt_r  <= tt;
      rc1_r <= in_reached;
      qhv_r <= QHW'(av[AW-1:24]) * QHW'(bv);
      qlv_r <= QLW'(av[23:0]) * QLW'(bv);
      qht_r <= QHW'(at[AW-1:24]) * QHW'(bt);
      qlt_r <= QLW'(at[23:0]) * QLW'(bt);
      nv_r  <= pv_r[PW-1] != tv_r[TW-1];
      nt_r  <= pt_r[PW-1] != tt_r[TW-1];
      rc2_r <= rc1_r;
      res_r <= res_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = res_r;

endmodule
